// File: hdl/rspn_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and the multiply-accumulate program for the ray hit unit
// no dependencies; used by every module of the block

package rspn_pkg;

	localparam int COORD_W   = 32;
	localparam int FRAC_BITS = 16;
	localparam int DIR_W     = 18;
	localparam int RAD_W     = 31;
	localparam int THR_W     = 16;
	localparam int T_W       = 31;

	localparam int OPND_W = COORD_W + 1;
	localparam int PROD_W = 2 * OPND_W;
	localparam int ACC_W  = 106;
	localparam int MAG_W  = 52;
	localparam int LIMB_W = MAG_W / 2;
	localparam int NN_W   = 2 * COORD_W;
	localparam int TH2_W  = 2 * THR_W;

	localparam int ROOT_W      = MAG_W;
	localparam int RADICAND_W  = 2 * ROOT_W;
	localparam int ROOT_STEPS  = ROOT_W;
	localparam int ROOT_CNT_W  = $clog2(ROOT_STEPS);
	localparam int NUM_MAG_W   = 2 * COORD_W;
	localparam int DIVIDEND_W  = NUM_MAG_W + FRAC_BITS;
	localparam int DIV_STEPS   = DIVIDEND_W;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	localparam int IN_DATA_BITS = 6 * COORD_W + RAD_W + 3 * DIR_W;
	localparam int IN_TDATA_W   = ((IN_DATA_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W  = ((1 + T_W + 7) / 8) * 8;

	localparam logic [T_W-1:0]   T_INF     = {T_W{1'b1}};
	localparam logic [T_W-1:0]   T_MAX     = {{(T_W-1){1'b1}}, 1'b0};
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

	localparam logic KIND_SPHERE = 1'b0;
	localparam logic KIND_PLANE  = 1'b1;

	localparam int PC_W = 5;
	localparam logic [PC_W-1:0] SPH_END = PC_W'(12);
	localparam logic [PC_W-1:0] PLN_END = PC_W'(20);

	typedef enum logic [3:0] {
		OPD_PX, OPD_PY, OPD_PZ, OPD_NX, OPD_NY, OPD_NZ, OPD_DX, OPD_DY,
		OPD_DZ, OPD_RAD, OPD_THR, OPD_TH2, OPD_MH, OPD_ML, OPD_NNH, OPD_NNL
	} opnd_t;

	typedef enum logic [1:0] {SHF_0, SHF_27, SHF_32, SHF_52} shf_t;

	typedef enum logic [2:0] {CAP_NONE, CAP_DOT, CAP_TH2, CAP_NN, CAP_TEST} cap_t;

	typedef enum logic [1:0] {SRC_NONE, SRC_ROOT, SRC_QUOT} src_t;

	typedef struct packed {
		logic  mul_en;
		opnd_t a;
		opnd_t b;
		shf_t  shf;
		logic  neg;
		logic  clr;
		cap_t  cap;
	} uop_t;

	typedef struct packed {
		logic load;
		logic issue;
		uop_t uop;
		logic root_start;
		logic div_start;
		logic fin;
		logic emit;
		src_t src;
	} dp_cmd_t;

	typedef struct packed {
		logic kind;
		logic last;
		logic acc_neg;
		logic plane_ok;
		logic root_done;
		logic div_done;
	} dp_stat_t;

	function automatic uop_t uop_mul(opnd_t a, opnd_t b, shf_t s, logic neg, logic clr);
		uop_t u;
		u.mul_en = 1'b1;
		u.a      = a;
		u.b      = b;
		u.shf    = s;
		u.neg    = neg;
		u.clr    = clr;
		u.cap    = CAP_NONE;
		return u;
	endfunction

	function automatic uop_t uop_cap(cap_t c);
		uop_t u;
		u        = '0;
		u.cap    = c;
		return u;
	endfunction

	// sphere: s = d.p, then h = |s|^2 + r^2<<32 - (p.p)<<32
	// plane: th2, den = n.d, nn = n.n, test = den^2 - th2*nn > 0, num = p.n
	function automatic uop_t uop_rom(logic kind, logic [PC_W-1:0] pc);
		uop_t u;
		u = uop_cap(CAP_NONE);
		if (kind == KIND_SPHERE) begin
			unique case (pc)
				5'd0:    u = uop_mul(OPD_DX, OPD_PX, SHF_0, 1'b0, 1'b1);
				5'd1:    u = uop_mul(OPD_DY, OPD_PY, SHF_0, 1'b0, 1'b0);
				5'd2:    u = uop_mul(OPD_DZ, OPD_PZ, SHF_0, 1'b0, 1'b0);
				5'd3:    u = uop_cap(CAP_DOT);
				5'd5:    u = uop_mul(OPD_MH, OPD_MH, SHF_52, 1'b0, 1'b1);
				5'd6:    u = uop_mul(OPD_MH, OPD_ML, SHF_27, 1'b0, 1'b0);
				5'd7:    u = uop_mul(OPD_ML, OPD_ML, SHF_0, 1'b0, 1'b0);
				5'd8:    u = uop_mul(OPD_RAD, OPD_RAD, SHF_32, 1'b0, 1'b0);
				5'd9:    u = uop_mul(OPD_PX, OPD_PX, SHF_32, 1'b1, 1'b0);
				5'd10:   u = uop_mul(OPD_PY, OPD_PY, SHF_32, 1'b1, 1'b0);
				5'd11:   u = uop_mul(OPD_PZ, OPD_PZ, SHF_32, 1'b1, 1'b0);
				default: u = uop_cap(CAP_NONE);
			endcase
		end else begin
			unique case (pc)
				5'd0:    u = uop_mul(OPD_THR, OPD_THR, SHF_0, 1'b0, 1'b1);
				5'd1:    u = uop_cap(CAP_TH2);
				5'd2:    u = uop_mul(OPD_NX, OPD_DX, SHF_0, 1'b0, 1'b1);
				5'd3:    u = uop_mul(OPD_NY, OPD_DY, SHF_0, 1'b0, 1'b0);
				5'd4:    u = uop_mul(OPD_NZ, OPD_DZ, SHF_0, 1'b0, 1'b0);
				5'd5:    u = uop_cap(CAP_DOT);
				5'd6:    u = uop_mul(OPD_NX, OPD_NX, SHF_0, 1'b0, 1'b1);
				5'd7:    u = uop_mul(OPD_NY, OPD_NY, SHF_0, 1'b0, 1'b0);
				5'd8:    u = uop_mul(OPD_NZ, OPD_NZ, SHF_0, 1'b0, 1'b0);
				5'd9:    u = uop_cap(CAP_NN);
				5'd11:   u = uop_mul(OPD_MH, OPD_MH, SHF_52, 1'b0, 1'b1);
				5'd12:   u = uop_mul(OPD_MH, OPD_ML, SHF_27, 1'b0, 1'b0);
				5'd13:   u = uop_mul(OPD_ML, OPD_ML, SHF_0, 1'b0, 1'b0);
				5'd14:   u = uop_mul(OPD_TH2, OPD_NNH, SHF_32, 1'b1, 1'b0);
				5'd15:   u = uop_mul(OPD_TH2, OPD_NNL, SHF_0, 1'b1, 1'b0);
				5'd16:   u = uop_cap(CAP_TEST);
				5'd17:   u = uop_mul(OPD_PX, OPD_NX, SHF_0, 1'b0, 1'b1);
				5'd18:   u = uop_mul(OPD_PY, OPD_NY, SHF_0, 1'b0, 1'b0);
				5'd19:   u = uop_mul(OPD_PZ, OPD_NZ, SHF_0, 1'b0, 1'b0);
				default: u = uop_cap(CAP_NONE);
			endcase
		end
		return u;
	endfunction

endpackage

// File: hdl/rspn_root.sv
`timescale 1ns / 1ps
// iterative integer square root, one result bit per cycle
// depends on rspn_pkg

module rspn_root (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [rspn_pkg::RADICAND_W-1:0]    radicand,
	output logic                               done,
	output logic [rspn_pkg::ROOT_W-1:0]        root
);

	logic [rspn_pkg::RADICAND_W-1:0] rad_q;
	logic [rspn_pkg::ROOT_W+1:0]     rem_q;
	logic [rspn_pkg::ROOT_W-1:0]     root_q;
	logic [rspn_pkg::ROOT_CNT_W-1:0] cnt_q;
	logic                            busy_q;
	logic                            done_q;

	logic [rspn_pkg::ROOT_W+3:0]     rem_sh;
	logic [rspn_pkg::ROOT_W+3:0]     trial;
	logic                            ge;

	assign rem_sh = {rem_q, rad_q[rspn_pkg::RADICAND_W-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rspn_pkg::ROOT_CNT_W'(rspn_pkg::ROOT_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[rspn_pkg::RADICAND_W-3:0], 2'b00};
			rem_q  <= ge ? (rspn_pkg::ROOT_W+2)'(rem_sh - trial)
			             : (rspn_pkg::ROOT_W+2)'(rem_sh);
			root_q <= {root_q[rspn_pkg::ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// File: hdl/rspn_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, quotient kept to the distance width with an overflow flag
// depends on rspn_pkg

module rspn_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [rspn_pkg::DIVIDEND_W-1:0]    dividend,
	input  logic [rspn_pkg::MAG_W-1:0]         divisor,
	output logic                               done,
	output logic [rspn_pkg::T_W-1:0]           quot,
	output logic                               ovf
);

	logic [rspn_pkg::DIVIDEND_W-1:0] dvd_q;
	logic [rspn_pkg::MAG_W-1:0]      dvs_q;
	logic [rspn_pkg::MAG_W-1:0]      rem_q;
	logic [rspn_pkg::T_W-1:0]        quot_q;
	logic                            ovf_q;
	logic [rspn_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic                            busy_q;
	logic                            done_q;

	logic [rspn_pkg::MAG_W:0]        rem_sh;
	logic                            ge;

	assign rem_sh = {rem_q, dvd_q[rspn_pkg::DIVIDEND_W-1]};
	assign ge     = (rem_sh >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rspn_pkg::DIV_CNT_W'(rspn_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// bits shifted past the top of the quotient only matter as overflow
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= dividend;
			dvs_q  <= divisor;
			rem_q  <= '0;
			quot_q <= '0;
			ovf_q  <= 1'b0;
		end else if (busy_q) begin
			dvd_q  <= {dvd_q[rspn_pkg::DIVIDEND_W-2:0], 1'b0};
			rem_q  <= ge ? rspn_pkg::MAG_W'(rem_sh - {1'b0, dvs_q})
			             : rspn_pkg::MAG_W'(rem_sh);
			quot_q <= {quot_q[rspn_pkg::T_W-2:0], ge};
			ovf_q  <= ovf_q | quot_q[rspn_pkg::T_W-1];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign ovf  = ovf_q;

endmodule

// File: hdl/rspn_dp.sv
`timescale 1ns / 1ps
// datapath: operand registers, shared multiply-accumulate, root and divide units, nearest hit
// depends on rspn_pkg, rspn_root, rspn_div

module rspn_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rspn_pkg::THR_W-1:0]          cfg_data,
	input  logic [rspn_pkg::IN_TDATA_W-1:0]     in_tdata,
	input  logic                                in_tuser,
	input  logic                                in_tlast,
	input  rspn_pkg::dp_cmd_t                   cmd,
	output rspn_pkg::dp_stat_t                  stat,
	output logic [rspn_pkg::OUT_TDATA_W-1:0]    out_tdata
);

	localparam int CW = rspn_pkg::COORD_W;
	localparam int DW = rspn_pkg::DIR_W;
	localparam int RW = rspn_pkg::RAD_W;
	localparam int AW = rspn_pkg::ACC_W;
	localparam int MW = rspn_pkg::MAG_W;
	localparam int TW = rspn_pkg::T_W;
	localparam int FB = rspn_pkg::FRAC_BITS;
	localparam int SW = MW + 2;
	localparam int RAD_LO = 6 * CW;
	localparam int DIR_LO = RAD_LO + RW;

	logic [rspn_pkg::THR_W-1:0] thr_q;
	logic signed [CW-1:0] px_q, py_q, pz_q, nx_q, ny_q, nz_q;
	logic signed [DW-1:0] dx_q, dy_q, dz_q;
	logic [RW-1:0]        rad_q;
	logic                 kind_q;
	logic                 last_q;

	logic signed [rspn_pkg::OPND_W-1:0] opa, opb;
	logic signed [rspn_pkg::PROD_W-1:0] prod_s1;
	rspn_pkg::uop_t                     uop_s1;
	logic signed [AW-1:0]               acc_q;
	logic signed [AW-1:0]               acc_abs;
	logic signed [AW-1:0]               term, term_sh, acc_base;

	logic signed [MW-1:0]               dot_q;
	logic [MW-1:0]                      mag_q;
	logic [rspn_pkg::TH2_W-1:0]         th2_q;
	logic [rspn_pkg::NN_W-1:0]          nn_q;
	logic                               test_q;

	logic                               root_done;
	logic [rspn_pkg::ROOT_W-1:0]        root;
	logic                               div_done;
	logic [TW-1:0]                      quot;
	logic                               ovf;

	logic signed [SW-1:0]               s_ext, q_ext, t_sub, t_add, t_sel;
	logic [SW-FB-2:0]                   tq;
	logic                               root_hit;
	logic [TW-1:0]                      root_t;
	logic                               quot_hit;
	logic [TW-1:0]                      quot_t;
	logic                               cand_hit;
	logic [TW-1:0]                      cand_t;
	logic [TW-1:0]                      nearest_q;
	logic [TW-1:0]                      merged;
	logic [TW-1:0]                      out_t_q;
	logic                               out_hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= rspn_pkg::THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q   <= in_tdata[0*CW +: CW];
			py_q   <= in_tdata[1*CW +: CW];
			pz_q   <= in_tdata[2*CW +: CW];
			nx_q   <= in_tdata[3*CW +: CW];
			ny_q   <= in_tdata[4*CW +: CW];
			nz_q   <= in_tdata[5*CW +: CW];
			rad_q  <= in_tdata[RAD_LO +: RW];
			dx_q   <= in_tdata[DIR_LO +: DW];
			dy_q   <= in_tdata[DIR_LO + DW +: DW];
			dz_q   <= in_tdata[DIR_LO + 2*DW +: DW];
			kind_q <= in_tuser;
			last_q <= in_tlast;
		end
	end

	function automatic logic signed [rspn_pkg::OPND_W-1:0] pick(
		rspn_pkg::opnd_t sel,
		logic signed [CW-1:0] px, logic signed [CW-1:0] py, logic signed [CW-1:0] pz,
		logic signed [CW-1:0] nx, logic signed [CW-1:0] ny, logic signed [CW-1:0] nz,
		logic signed [DW-1:0] dx, logic signed [DW-1:0] dy, logic signed [DW-1:0] dz,
		logic [RW-1:0] r, logic [rspn_pkg::THR_W-1:0] thr, logic [rspn_pkg::TH2_W-1:0] th2,
		logic [MW-1:0] mag, logic [rspn_pkg::NN_W-1:0] nn);
		logic signed [rspn_pkg::OPND_W-1:0] v;
		unique case (sel)
			rspn_pkg::OPD_PX:  v = rspn_pkg::OPND_W'(px);
			rspn_pkg::OPD_PY:  v = rspn_pkg::OPND_W'(py);
			rspn_pkg::OPD_PZ:  v = rspn_pkg::OPND_W'(pz);
			rspn_pkg::OPD_NX:  v = rspn_pkg::OPND_W'(nx);
			rspn_pkg::OPD_NY:  v = rspn_pkg::OPND_W'(ny);
			rspn_pkg::OPD_NZ:  v = rspn_pkg::OPND_W'(nz);
			rspn_pkg::OPD_DX:  v = rspn_pkg::OPND_W'(dx);
			rspn_pkg::OPD_DY:  v = rspn_pkg::OPND_W'(dy);
			rspn_pkg::OPD_DZ:  v = rspn_pkg::OPND_W'(dz);
			rspn_pkg::OPD_RAD: v = rspn_pkg::OPND_W'(r);
			rspn_pkg::OPD_THR: v = rspn_pkg::OPND_W'(thr);
			rspn_pkg::OPD_TH2: v = rspn_pkg::OPND_W'(th2);
			rspn_pkg::OPD_MH:  v = rspn_pkg::OPND_W'(mag[MW-1:rspn_pkg::LIMB_W]);
			rspn_pkg::OPD_ML:  v = rspn_pkg::OPND_W'(mag[rspn_pkg::LIMB_W-1:0]);
			rspn_pkg::OPD_NNH: v = rspn_pkg::OPND_W'(nn[rspn_pkg::NN_W-1:CW]);
			rspn_pkg::OPD_NNL: v = rspn_pkg::OPND_W'(nn[CW-1:0]);
			default:           v = '0;
		endcase
		return v;
	endfunction

	assign opa = pick(cmd.uop.a, px_q, py_q, pz_q, nx_q, ny_q, nz_q, dx_q, dy_q, dz_q,
	                  rad_q, thr_q, th2_q, mag_q, nn_q);
	assign opb = pick(cmd.uop.b, px_q, py_q, pz_q, nx_q, ny_q, nz_q, dx_q, dy_q, dz_q,
	                  rad_q, thr_q, th2_q, mag_q, nn_q);

	// multiply stage
	always_ff @(posedge clk) begin
		prod_s1 <= opa * opb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uop_s1 <= '0;
		end else begin
			uop_s1 <= cmd.issue ? cmd.uop : rspn_pkg::uop_cap(rspn_pkg::CAP_NONE);
		end
	end

	// accumulate stage
	always_comb begin
		term = AW'(prod_s1);
		unique case (uop_s1.shf)
			rspn_pkg::SHF_0:  term_sh = term;
			rspn_pkg::SHF_27: term_sh = term <<< 27;
			rspn_pkg::SHF_32: term_sh = term <<< 32;
			rspn_pkg::SHF_52: term_sh = term <<< 52;
			default:          term_sh = term;
		endcase
		acc_base = uop_s1.clr ? '0 : acc_q;
	end

	assign acc_abs = acc_q[AW-1] ? -acc_q : acc_q;

	always_ff @(posedge clk) begin
		if (uop_s1.mul_en) begin
			acc_q <= uop_s1.neg ? (acc_base - term_sh) : (acc_base + term_sh);
		end
		unique case (uop_s1.cap)
			rspn_pkg::CAP_DOT: begin
				dot_q <= acc_q[MW-1:0];
				mag_q <= acc_abs[MW-1:0];
			end
			rspn_pkg::CAP_TH2:  th2_q  <= acc_q[rspn_pkg::TH2_W-1:0];
			rspn_pkg::CAP_NN:   nn_q   <= acc_q[rspn_pkg::NN_W-1:0];
			rspn_pkg::CAP_TEST: test_q <= !acc_q[AW-1] && (acc_q != '0);
			default: ;
		endcase
	end

	rspn_root u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.root_start),
		.radicand (acc_q[rspn_pkg::RADICAND_W-1:0]),
		.done     (root_done),
		.root     (root)
	);

	rspn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({acc_abs[rspn_pkg::NUM_MAG_W-1:0], {FB{1'b0}}}),
		.divisor  (mag_q),
		.done     (div_done),
		.quot     (quot),
		.ovf      (ovf)
	);

	// sphere distance: s - q, or s + q when that is negative; then the chosen candidate, merged if strictly nearer
	always_comb begin
		s_ext    = SW'(dot_q);
		q_ext    = $signed({2'b00, root});
		t_sub    = s_ext - q_ext;
		t_add    = s_ext + q_ext;
		t_sel    = t_sub[SW-1] ? t_add : t_sub;
		tq       = t_sel[SW-2:FB];
		root_hit = !t_sel[SW-1] && (tq != '0);
		root_t   = (tq > (SW-FB-1)'(rspn_pkg::T_MAX)) ? rspn_pkg::T_MAX : tq[TW-1:0];
		quot_hit = ovf || (quot != '0);
		quot_t   = (ovf || (quot == rspn_pkg::T_INF)) ? rspn_pkg::T_MAX : quot;
		unique case (cmd.src)
			rspn_pkg::SRC_ROOT: begin
				cand_hit = root_hit;
				cand_t   = root_t;
			end
			rspn_pkg::SRC_QUOT: begin
				cand_hit = quot_hit;
				cand_t   = quot_t;
			end
			default: begin
				cand_hit = 1'b0;
				cand_t   = rspn_pkg::T_INF;
			end
		endcase
		merged = (cand_hit && (cand_t < nearest_q)) ? cand_t : nearest_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nearest_q <= rspn_pkg::T_INF;
		end else if (cmd.emit) begin
			nearest_q <= rspn_pkg::T_INF;
		end else if (cmd.fin) begin
			nearest_q <= merged;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_t_q   <= merged;
			out_hit_q <= (merged != rspn_pkg::T_INF);
		end
	end

	assign out_tdata = rspn_pkg::OUT_TDATA_W'({out_t_q, out_hit_q});

	assign stat.kind      = kind_q;
	assign stat.last      = last_q;
	assign stat.acc_neg   = acc_q[AW-1];
	assign stat.plane_ok  = test_q && (acc_q != '0) && (acc_q[AW-1] == dot_q[MW-1]);
	assign stat.root_done = root_done;
	assign stat.div_done  = div_done;

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> (mag_q != '0))
		else $error("divide started with a zero denominator");

	a_root_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.root_start |-> !acc_q[AW-1])
		else $error("root started on a negative discriminant");

	a_cand_finite: assert property (@(posedge clk) disable iff (!arst_n)
		cand_hit |-> (cand_t != rspn_pkg::T_INF))
		else $error("hit candidate reads as infinity");

	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (nearest_q == rspn_pkg::T_INF))
		else $error("nearest distance not re-armed after a result");

endmodule

// File: hdl/rspn_ctrl.sv
`timescale 1ns / 1ps
// controller: input and output handshakes, program sequencing, unit start and wait
// depends on rspn_pkg

module rspn_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  rspn_pkg::dp_stat_t  stat,
	output rspn_pkg::dp_cmd_t   cmd
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_PROG = 6'b000010,
		ST_EVAL = 6'b000100,
		ST_ROOT = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	state_t                    state_q, state_d;
	logic [rspn_pkg::PC_W-1:0] pc_q, pc_d;
	rspn_pkg::src_t            src_q, src_d;
	logic                      out_valid_q, out_valid_d;
	logic [rspn_pkg::PC_W-1:0] pc_end;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign pc_end    = (stat.kind == rspn_pkg::KIND_PLANE) ? rspn_pkg::PLN_END
	                                                       : rspn_pkg::SPH_END;

	always_comb begin
		state_d = state_q;
		pc_d    = pc_q;
		src_d   = src_q;
		cmd     = '0;
		cmd.src = src_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					pc_d     = '0;
					state_d  = ST_PROG;
				end
			end
			ST_PROG: begin
				cmd.issue = 1'b1;
				cmd.uop   = rspn_pkg::uop_rom(stat.kind, pc_q);
				pc_d      = pc_q + 1'b1;
				if (pc_q == pc_end) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				src_d = rspn_pkg::SRC_NONE;
				if (stat.kind == rspn_pkg::KIND_SPHERE) begin
					if (stat.acc_neg) begin
						state_d = ST_FIN;
					end else begin
						cmd.root_start = 1'b1;
						state_d        = ST_ROOT;
					end
				end else begin
					if (stat.plane_ok) begin
						cmd.div_start = 1'b1;
						state_d       = ST_DIV;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_ROOT: begin
				if (stat.root_done) begin
					src_d   = rspn_pkg::SRC_ROOT;
					state_d = ST_FIN;
				end
			end
			ST_DIV: begin
				if (stat.div_done) begin
					src_d   = rspn_pkg::SRC_QUOT;
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!stat.last) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end else if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		out_valid_d = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pc_q        <= '0;
			src_q       <= rspn_pkg::SRC_NONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			pc_q        <= pc_d;
			src_q       <= src_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

// File: hdl/ray_sphere_plane_nearest_hit_unit.sv
`timescale 1ns / 1ps
// top level of the nearest-hit ray caster against spheres and planes
// depends on rspn_pkg, rspn_ctrl, rspn_dp (and through it rspn_root, rspn_div)
//
// usage:
//  - s_axis carries one scene object per transaction; the ray starts at the origin and
//    runs along the direction in the object; tuser picks sphere (0) or plane (1), tlast
//    marks the final object of a ray
//  - m_axis carries one result per ray, after the object with tlast: the hit flag and
//    the nearest positive distance (all ones when nothing was hit)
//  - cfg_* writes the plane threshold; it is always ready, write only while the unit idles
// timing:
//  - objects are processed one at a time; s_axis_tready is high only while idle
//  - a sphere's time is set by the 52-step square root, skipped when the discriminant is negative
//  - a plane's time is set by the 80-step divide, which is skipped when it fails the tests
//  - the shared multiplier runs 13 (sphere) or 21 (plane) program steps before that
//  - a result appears in the cycle after the final object finishes
// reset clears the threshold to 1, the nearest distance to infinity and drops m_axis_tvalid.
// a stalled m_axis holds its result; the unit keeps taking objects and only waits when
// the next ray's result is ready before the previous one has been taken

module ray_sphere_plane_nearest_hit_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// config: parallel threshold, unsigned Q0.16
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rspn_pkg::THR_W-1:0]          cfg_data,
	// object stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// obj_x, obj_y, obj_z, norm_x, norm_y, norm_z, radius, dir_x, dir_y, dir_z, zero pad
	input  logic [rspn_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// cmd: 0 sphere, 1 plane
	input  logic                                s_axis_tuser,
	// last_object
	input  logic                                s_axis_tlast,
	// result stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// hit, nearest_t
	output logic [rspn_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

	rspn_pkg::dp_cmd_t  cmd;
	rspn_pkg::dp_stat_t stat;

	// threshold register takes every write in the same cycle
	assign cfg_ready = 1'b1;

	rspn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rspn_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_data  (cfg_data),
		.in_tdata  (s_axis_tdata),
		.in_tuser  (s_axis_tuser),
		.in_tlast  (s_axis_tlast),
		.cmd       (cmd),
		.stat      (stat),
		.out_tdata (m_axis_tdata)
	);

endmodule

// File: tb/ray_sphere_plane_nearest_hit_unit_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the sphere/plane nearest-hit ray caster
// depends on rspn_pkg and ray_sphere_plane_nearest_hit_unit; random rays and a directed
// table are checked against an exact 128-bit software predictor of the hit distance or typed results

module ray_sphere_plane_nearest_hit_unit_tb;

	typedef logic signed [127:0] wide_t;

	// one scene object as it travels on s_axis
	typedef struct {
		logic                                kind;
		logic signed [rspn_pkg::COORD_W-1:0] px, py, pz;
		logic signed [rspn_pkg::COORD_W-1:0] nx, ny, nz;
		logic [rspn_pkg::RAD_W-1:0]          rad;
		logic signed [rspn_pkg::DIR_W-1:0]   dx, dy, dz;
		logic                                last;
	} scene_obj_t;

	typedef struct {
		logic                     hit;
		logic [rspn_pkg::T_W-1:0] t_near;
	} ray_result_t;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [rspn_pkg::THR_W-1:0]       cfg_data;
	logic                             s_axis_tvalid;
	logic                             s_axis_tready;
	logic [rspn_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
	logic                             s_axis_tuser;
	logic                             s_axis_tlast;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready;
	logic [rspn_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

	ray_sphere_plane_nearest_hit_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// predictor state: its own copy of the threshold and the running nearest distance
	logic [rspn_pkg::THR_W-1:0] model_thr;
	logic [rspn_pkg::T_W-1:0]   model_nearest;

	ray_result_t pending_results[$];
	int          fail_count;
	int          mismatch_count;
	int          results_seen;
	int          hits_seen;
	int          objects_sent;
	int          tx_idle_pct;
	int          rx_idle_pct;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#40_000_000;
		$display("timeout with %0d results still pending", pending_results.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ---------------- predictor ----------------

	function automatic logic [63:0] int_sqrt(logic [127:0] h);
		logic [63:0]  r;
		logic [127:0] c;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			c = {64'd0, r | (64'd1 << i)};
			if (c * c <= h)
				r = c[63:0];
		end
		return r;
	endfunction

	function automatic logic [rspn_pkg::T_W-1:0] clamp_dist(logic [127:0] q);
		if (q > {97'd0, rspn_pkg::T_MAX})
			return rspn_pkg::T_MAX;
		return q[rspn_pkg::T_W-1:0];
	endfunction

	// distance to one object, 0 when it gives no hit
	function automatic logic [rspn_pkg::T_W-1:0] object_dist(scene_obj_t o,
		logic [rspn_pkg::THR_W-1:0] thr);
		wide_t px, py, pz, nx, ny, nz, dx, dy, dz;
		wide_t s, pp, rr, sm, a, b, q, t1;
		wide_t den, nn, num, dm, th2;
		px = o.px; py = o.py; pz = o.pz;
		nx = o.nx; ny = o.ny; nz = o.nz;
		dx = o.dx; dy = o.dy; dz = o.dz;
		if (o.kind == rspn_pkg::KIND_SPHERE) begin
			s  = dx * px + dy * py + dz * pz;
			pp = px * px + py * py + pz * pz;
			rr = {97'd0, o.rad};
			rr = rr * rr;
			sm = (s < 0) ? -s : s;
			a  = sm * sm + (rr << (2 * rspn_pkg::FRAC_BITS));
			b  = pp << (2 * rspn_pkg::FRAC_BITS);
			if ($unsigned(a) < $unsigned(b))
				return '0;
			q  = {64'd0, int_sqrt(a - b)};
			t1 = s - q;
			if (t1 < 0)
				t1 = s + q;
			if (t1 < 0)
				return '0;
			return clamp_dist(t1 >>> rspn_pkg::FRAC_BITS);
		end
		den = nx * dx + ny * dy + nz * dz;
		nn  = nx * nx + ny * ny + nz * nz;
		num = px * nx + py * ny + pz * nz;
		dm  = (den < 0) ? -den : den;
		th2 = {112'd0, thr};
		th2 = th2 * th2;
		// parallel test in squared form, strict
		if (!($unsigned(th2 * nn) < $unsigned(dm * dm)))
			return '0;
		if (num == 0 || ((num < 0) != (den < 0)))
			return '0;
		if (num < 0)
			num = -num;
		q = $unsigned(num << rspn_pkg::FRAC_BITS) / $unsigned(dm);
		return clamp_dist(q);
	endfunction

	// update the running nearest distance; returns 1 when the object closes a ray
	function automatic logic trace_object(scene_obj_t o, output ray_result_t res);
		logic [rspn_pkg::T_W-1:0] t;
		t = object_dist(o, model_thr);
		if (t != 0 && t < model_nearest)
			model_nearest = t;
		res.hit    = (model_nearest != rspn_pkg::T_INF);
		res.t_near = model_nearest;
		if (o.last)
			model_nearest = rspn_pkg::T_INF;
		return o.last;
	endfunction

	// ---------------- drivers ----------------

	function automatic logic [rspn_pkg::IN_TDATA_W-1:0] pack_obj(scene_obj_t o);
		return rspn_pkg::IN_TDATA_W'({o.dz, o.dy, o.dx, o.rad, o.nz, o.ny, o.nx,
			o.pz, o.py, o.px});
	endfunction

	// called at a falling edge, returns at a falling edge after the transaction
	task automatic send_obj(scene_obj_t o, logic typed, ray_result_t typed_res);
		ray_result_t res;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pack_obj(o);
		s_axis_tuser  <= o.kind;
		s_axis_tlast  <= o.last;
		if (trace_object(o, res)) begin
			if (typed)
				pending_results.push_back(typed_res);
			else
				pending_results.push_back(res);
		end
		do @(posedge clk); while (!s_axis_tready);
		objects_sent++;
		@(negedge clk);
	endtask

	task automatic write_threshold(logic [rspn_pkg::THR_W-1:0] v);
		s_axis_tvalid <= 1'b0;
		cfg_valid     <= 1'b1;
		cfg_data      <= v;
		do @(posedge clk); while (!cfg_ready);
		model_thr = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait for every result, then let any object still in flight finish
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	// receiver back-pressure
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (m_axis_tdata[0])
				hits_seen++;
			if (pending_results.size() == 0) begin
				fail_count++;
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result transaction: %h", m_axis_tdata);
			end else begin
				ray_result_t e;
				e = pending_results.pop_front();
				if (m_axis_tdata[0] !== e.hit ||
				    m_axis_tdata[rspn_pkg::T_W:1] !== e.t_near) begin
					fail_count++;
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result %0d mismatch: hit %b/%b t %h/%h (exp/got)",
							results_seen, e.hit, m_axis_tdata[0], e.t_near,
							m_axis_tdata[rspn_pkg::T_W:1]);
				end
			end
		end
	end

	// ---------------- stimulus ----------------

	function automatic scene_obj_t mk_obj(logic kind, int px, int py, int pz,
		int nx, int ny, int nz, int rad, int dx, int dy, int dz, logic last);
		scene_obj_t o;
		o.kind = kind;
		o.px = px; o.py = py; o.pz = pz;
		o.nx = nx; o.ny = ny; o.nz = nz;
		o.rad = rad[rspn_pkg::RAD_W-1:0];
		o.dx = dx[rspn_pkg::DIR_W-1:0];
		o.dy = dy[rspn_pkg::DIR_W-1:0];
		o.dz = dz[rspn_pkg::DIR_W-1:0];
		o.last = last;
		return o;
	endfunction

	function automatic int rnd_dir();
		return int'($urandom_range(131072)) - 65536;
	endfunction

	function automatic int rnd_span(int half);
		return int'($urandom_range(2 * half)) - half;
	endfunction

	// noise: kind, position, normal and radius anywhere in their range, direction within +/-65536
	function automatic scene_obj_t noise_obj(logic last);
		return mk_obj($urandom_range(1), $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, rnd_dir(), rnd_dir(), rnd_dir(), last);
	endfunction

	// plausible object for a ray: spheres placed near the ray, planes at moderate range
	function automatic scene_obj_t scene_obj(int dx, int dy, int dz, logic last);
		longint k;
		int     jit;
		k   = $urandom_range(1 << 26);
		jit = 1 << $urandom_range(20, 10);
		if ($urandom_range(1))
			return mk_obj(rspn_pkg::KIND_PLANE, rnd_span(1 << 26), rnd_span(1 << 26),
				rnd_span(1 << 26), rnd_span(1 << 18), rnd_span(1 << 18),
				rnd_span(1 << 18), $urandom, dx, dy, dz, last);
		return mk_obj(rspn_pkg::KIND_SPHERE, int'((dx * k) >>> 16) + rnd_span(jit),
			int'((dy * k) >>> 16) + rnd_span(jit), int'((dz * k) >>> 16) + rnd_span(jit),
			$urandom, $urandom, $urandom, $urandom_range(1 << 21), dx, dy, dz, last);
	endfunction

	localparam int N_DIRECTED = 14;

	initial begin
		scene_obj_t  dir_tab[N_DIRECTED];
		logic        typed_tab[N_DIRECTED];
		ray_result_t typed_res[N_DIRECTED];
		ray_result_t none_res;
		logic [rspn_pkg::THR_W-1:0] seg_thr[4];
		int          seg_tx[4];
		int          seg_rx[4];
		int          dx, dy, dz, n_obj;

		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		s_axis_tlast  = 1'b0;
		fail_count    = 0;
		mismatch_count = 0;
		results_seen  = 0;
		hits_seen     = 0;
		objects_sent  = 0;
		tx_idle_pct   = 9;
		rx_idle_pct   = 77;
		model_thr     = rspn_pkg::THR_RESET;
		model_nearest = rspn_pkg::T_INF;
		none_res.hit    = 1'b0;
		none_res.t_near = rspn_pkg::T_INF;

		// directed objects; typed rows can be read off at a glance
		dir_tab[0]  = mk_obj(rspn_pkg::KIND_SPHERE, 100 << 16, 0, 0, 0, 0, 0, 1 << 16,
			0, 0, 65536, 1);
		dir_tab[1]  = mk_obj(rspn_pkg::KIND_SPHERE, 0, 0, 10 << 16, 0, 0, 0, 1 << 16,
			0, 0, 65536, 1);
		dir_tab[2]  = mk_obj(rspn_pkg::KIND_SPHERE, 0, 0, 0, 0, 0, 0, 5 << 16,
			0, 0, 65536, 1);
		dir_tab[3]  = mk_obj(rspn_pkg::KIND_PLANE, 0, 0, 3 << 16, 0, 0, 0, 0,
			0, 0, 65536, 1);
		dir_tab[4]  = mk_obj(rspn_pkg::KIND_PLANE, 0, 0, 32'h7FFF_FFFF, 0, 0, 1 << 16, 0,
			0, 0, 2, 1);
		dir_tab[5]  = mk_obj(rspn_pkg::KIND_PLANE, 0, 0, -(10 << 16), 0, 0, 1 << 16, 0,
			0, 0, 65536, 1);
		dir_tab[6]  = mk_obj(rspn_pkg::KIND_PLANE, 0, 0, 3 << 16, 0, 0, 1 << 16, 0,
			0, 0, 65536, 0);
		dir_tab[7]  = mk_obj(rspn_pkg::KIND_SPHERE, 0, 0, 20 << 16, 0, 0, 0, 1 << 16,
			0, 0, 65536, 0);
		dir_tab[8]  = mk_obj(rspn_pkg::KIND_SPHERE, 0, 0, 1, 0, 0, 0, 0, 0, 0, 65536, 1);
		dir_tab[9]  = mk_obj(rspn_pkg::KIND_SPHERE, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			65536, 65536, 65536, 0);
		dir_tab[10] = mk_obj(rspn_pkg::KIND_PLANE, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0,
			-65536, -65536, -65536, 1);
		dir_tab[11] = mk_obj(rspn_pkg::KIND_PLANE, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			65536, 65536, 65536, 1);
		dir_tab[12] = mk_obj(rspn_pkg::KIND_SPHERE, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 0, 0, 0, 32'h7FFF_FFFF, -65536, -65536, -65536, 1);
		dir_tab[13] = mk_obj(rspn_pkg::KIND_SPHERE, 0, 0, 4 << 16, 0, 0, 0, 1 << 16,
			0, 0, 0, 1);
		for (int i = 0; i < N_DIRECTED; i++) begin
			typed_tab[i] = 1'b0;
			typed_res[i] = none_res;
		end
		// sphere off to the side: miss
		typed_tab[0] = 1'b1;
		// sphere ten units ahead, radius one: near surface at nine
		typed_tab[1] = 1'b1;
		typed_res[1].hit    = 1'b1;
		typed_res[1].t_near = rspn_pkg::T_W'(32'h0009_0000);
		// zero normal never passes the parallel test
		typed_tab[3] = 1'b1;
		// huge distance saturates but stays a hit
		typed_tab[4] = 1'b1;
		typed_res[4].hit    = 1'b1;
		typed_res[4].t_near = rspn_pkg::T_MAX;
		// plane behind the origin
		typed_tab[5] = 1'b1;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_obj(dir_tab[i], typed_tab[i], typed_res[i]);

		// sender holds off until every directed result is back
		drain();

		seg_thr[0] = '0;
		seg_thr[1] = rspn_pkg::THR_W'($urandom_range(1000, 1));
		seg_thr[2] = '1;
		seg_thr[3] = rspn_pkg::THR_RESET;
		seg_tx = '{9, 77, 0, 0};
		seg_rx = '{77, 9, 0, 0};
		for (int seg = 0; seg < 4; seg++) begin
			write_threshold(seg_thr[seg]);
			tx_idle_pct = seg_tx[seg];
			rx_idle_pct = seg_rx[seg];
			for (int sent = 0; sent < 450; sent += n_obj) begin
				n_obj = $urandom_range(6, 1);
				if ($urandom_range(3) == 0) begin
					// axis-aligned ray
					dx = 0; dy = 0; dz = 0;
					case ($urandom_range(2))
						0: dx = $urandom_range(1) ? 65536 : -65536;
						1: dy = $urandom_range(1) ? 65536 : -65536;
						default: dz = $urandom_range(1) ? 65536 : -65536;
					endcase
				end else begin
					dx = rnd_dir(); dy = rnd_dir(); dz = rnd_dir();
				end
				for (int j = 0; j < n_obj; j++) begin
					if ($urandom_range(9) == 0)
						send_obj(noise_obj(j == n_obj - 1), 1'b0, none_res);
					else
						send_obj(scene_obj(dx, dy, dz, j == n_obj - 1), 1'b0, none_res);
				end
			end
			drain();
		end

		$display("covered %0d objects and %0d rays (%0d hits) over thresholds 0, mid, max, 1",
			objects_sent, results_seen, hits_seen);
		$display("with stalls on either side and without; %0d mismatches", mismatch_count);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
